// File: rtl/gbcc_pkg.sv
// ----------------------------------------------------------------------------
// gbcc_pkg
// Shared types and constants for the gyro bias calibrate/correct block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbcc_pkg;

  // Sample and register widths fixed by the stream format
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 4;

  // Default upper bound on the averaging shift
  localparam int MAX_AVG_SHIFT_DEF = 12;

  // Averaging shift after reset
  localparam logic [CFG_W-1:0] AVG_SHIFT_RST = CFG_W'(11);

  // Sample kind carried on the input tuser
  localparam logic MODE_CALIB   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  // One input beat
  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } sample_t;

  // One result beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic                       done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/gbcc_calib.sv
// ----------------------------------------------------------------------------
// gbcc_calib
// Bias accumulators, sample counter, offsets and the correction subtract.
// State advances once per step; the result uses the offsets held before it.
// ----------------------------------------------------------------------------
`default_nettype none

module gbcc_calib #(
  parameter int MAX_AVG_SHIFT = gbcc_pkg::MAX_AVG_SHIFT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gbcc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           step,
  input  wire gbcc_pkg::sample_t              smp,
  output gbcc_pkg::result_t                   res
);
  import gbcc_pkg::*;

  localparam int SUM_W = SAMPLE_W + MAX_AVG_SHIFT;
  localparam int CNT_W = MAX_AVG_SHIFT + 1;
  localparam int SH_W  = $clog2(MAX_AVG_SHIFT + 1);
  localparam logic [CFG_W:0] MAX_SH = (CFG_W + 1)'(MAX_AVG_SHIFT);

  logic [CFG_W-1:0]           avg_shift;
  logic signed [SUM_W-1:0]    sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]           samples_taken;
  logic signed [SAMPLE_W-1:0] offset_x, offset_y, offset_z;

  logic [CFG_W:0]             shift_ext;
  logic [SH_W-1:0]            sh;
  logic [CNT_W-1:0]           cnt_next;
  logic [CNT_W-1:0]           threshold;
  logic                       run_done;
  logic signed [SUM_W-1:0]    sum_x_next, sum_y_next, sum_z_next;
  logic signed [SUM_W-1:0]    mean_x, mean_y, mean_z;

  // Clamp the shift to the supported range
  always_comb begin
    shift_ext = (CFG_W + 1)'(avg_shift);
    if (shift_ext > MAX_SH) begin
      shift_ext = MAX_SH;
    end
    sh = shift_ext[SH_W-1:0];
  end

  // Accumulate, count and test for the end of a run
  always_comb begin
    sum_x_next = sum_x + SUM_W'(smp.x);
    sum_y_next = sum_y + SUM_W'(smp.y);
    sum_z_next = sum_z + SUM_W'(smp.z);
    cnt_next   = samples_taken + CNT_W'(1);
    threshold  = CNT_W'(1) << sh;
    run_done   = (smp.mode == MODE_CALIB) && (cnt_next >= threshold);
    // Floor mean: arithmetic shift of the signed sum
    mean_x     = sum_x_next >>> sh;
    mean_y     = sum_y_next >>> sh;
    mean_z     = sum_z_next >>> sh;
  end

  // Correction against the offsets in force before this beat
  always_comb begin
    res.x    = smp.x - offset_x;
    res.y    = smp.y - offset_y;
    res.z    = smp.z - offset_z;
    res.done = run_done;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_shift <= AVG_SHIFT_RST;
    end else if (cfg_we) begin
      avg_shift <= cfg_wdata;
    end
  end

  // Calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      samples_taken <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
      offset_z      <= '0;
    end else if (step && (smp.mode == MODE_CALIB)) begin
      if (run_done) begin
        offset_x      <= mean_x[SAMPLE_W-1:0];
        offset_y      <= mean_y[SAMPLE_W-1:0];
        offset_z      <= mean_z[SAMPLE_W-1:0];
        sum_x         <= '0;
        sum_y         <= '0;
        sum_z         <= '0;
        samples_taken <= '0;
      end else begin
        sum_x         <= sum_x_next;
        sum_y         <= sum_y_next;
        sum_z         <= sum_z_next;
        samples_taken <= cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/gyro_bias_calibrate_correct_core.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_correct_core
// Three-axis gyro bias calibration and offset correction on a sample stream.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_*      in   tdata: sample_x, sample_y, sample_z; tuser: mode
//  m_*      out  tdata: corrected_x, corrected_y, corrected_z; tuser: calibration_done
//  cfg_*    in   avg_shift write, no read-back
//
// One beat per cycle sustained while m_tready is high; an accepted s beat
// is captured in an input register, then combinational accumulate, shift
// and subtract loads the result register.
// A stalled m side holds the result; the input register still takes one beat.
// rst is synchronous; offsets, sums and count clear, avg_shift returns to 11.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_bias_calibrate_correct_core #(
  parameter int MAX_AVG_SHIFT = gbcc_pkg::MAX_AVG_SHIFT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config
  input  wire logic                             cfg_we,
  input  wire logic [gbcc_pkg::CFG_W-1:0]       cfg_wdata,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [3*gbcc_pkg::SAMPLE_W-1:0]  s_tdata,  // sample_x, sample_y, sample_z
  input  wire logic                             s_tuser,  // mode
  // output stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [3*gbcc_pkg::SAMPLE_W-1:0]       m_tdata,  // corrected_x, corrected_y, corrected_z
  output logic                                  m_tuser   // calibration_done
);
  import gbcc_pkg::*;

  logic    in_valid;
  sample_t in_smp;
  logic    out_free;
  logic    step;
  result_t res;
  result_t out_res;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_smp.mode <= s_tuser;
      in_smp.x    <= s_tdata[SAMPLE_W-1:0];
      in_smp.y    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      in_smp.z    <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
    end
  end

  // Calibration state and correction
  gbcc_calib #(
    .MAX_AVG_SHIFT (MAX_AVG_SHIFT)
  ) u_calib (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .smp       (in_smp),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.z, out_res.y, out_res.x};
  assign m_tuser = out_res.done;

endmodule

`default_nettype wire
